@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define QBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define QBC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/qbc_pkg.sv @@
package qbc_pkg;

    localparam int NUM_QUADRANTS = 4;
    localparam int SYMBOLS       = 77;
    localparam int QUEUE_DEPTH   = 2;
    localparam int SYM_IX_W      = $clog2(SYMBOLS);
    localparam int QUAD_W        = $clog2(NUM_QUADRANTS);

    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam logic REG_DROP_CR_EOF = 1'b0;

    localparam logic [7:0] LOW_CODE  = 8'h40;
    localparam logic [7:0] HIGH_CODE = 8'hf9;
    localparam logic [7:0] NULL_CODE = 8'hc1;
    localparam logic [7:0] CR_BYTE   = 8'h0d;
    localparam logic [7:0] EOF_BYTE  = 8'h1a;
    localparam logic [QUAD_W-1:0] NULL_QUADRANT = QUAD_W'(2);

    localparam logic [7:0] SEL_BYTE [NUM_QUADRANTS] = '{8'h5e, 8'h7e, 8'h5c, 8'h7d};

    localparam logic [7:0] QTAB [NUM_QUADRANTS][SYMBOLS] = '{
        '{8'h40,8'hc1,8'hc2,8'hc3,8'hc4,8'hc5,8'hc6,8'hc7,8'hc8,8'hc9,8'hd1,8'hd2,
          8'hd3,8'hd4,8'hd5,8'hd6,8'hd7,8'hd8,8'hd9,8'he2,8'he3,8'he4,8'he5,8'he6,
          8'he7,8'he8,8'he9,8'h81,8'h82,8'h83,8'h84,8'h85,8'h86,8'h87,8'h88,8'h89,
          8'h91,8'h92,8'h93,8'h94,8'h95,8'h96,8'h97,8'h98,8'h99,8'ha2,8'ha3,8'ha4,
          8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'hf0,8'hf1,8'hf2,8'hf3,8'hf4,8'hf5,8'hf6,
          8'hf7,8'hf8,8'hf9,8'h6c,8'h50,8'h6d,8'h4d,8'h5d,8'h4c,8'h4e,8'h6b,8'h60,
          8'h4b,8'h61,8'h7a,8'h6e,8'h6f},
        '{8'h20,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,8'h4a,8'h4b,
          8'h4c,8'h4d,8'h4e,8'h4f,8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
          8'h58,8'h59,8'h5a,8'h61,8'h62,8'h63,8'h64,8'h65,8'h66,8'h67,8'h68,8'h69,
          8'h6a,8'h6b,8'h6c,8'h6d,8'h6e,8'h6f,8'h70,8'h71,8'h72,8'h73,8'h74,8'h75,
          8'h76,8'h77,8'h78,8'h79,8'h7a,8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,
          8'h37,8'h38,8'h39,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2a,8'h2b,8'h2c,8'h2d,
          8'h2e,8'h2f,8'h3a,8'h3b,8'h3f},
        '{8'h00,8'h00,8'h01,8'h02,8'h03,8'h04,8'h05,8'h06,8'h07,8'h08,8'h09,8'h0a,
          8'h0b,8'h0c,8'h0d,8'h0e,8'h0f,8'h10,8'h11,8'h12,8'h13,8'h14,8'h15,8'h16,
          8'h17,8'h18,8'h19,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h3c,8'h3d,8'h3e,8'h00,8'hfa,8'hfb,8'hfc,
          8'hfd,8'hfe,8'hff,8'h7b,8'h7c,8'h7d,8'h7e,8'h7f,8'h1a,8'h1b,8'h1c,8'h1d,
          8'h1e,8'h1f,8'h00,8'h00,8'h00},
        '{8'h00,8'ha0,8'ha1,8'hea,8'heb,8'hec,8'hed,8'hee,8'hef,8'he0,8'he1,8'haa,
          8'hab,8'hac,8'had,8'hae,8'haf,8'hb0,8'hb1,8'hb2,8'hb3,8'hb4,8'hb5,8'hb6,
          8'hb7,8'hb8,8'hb9,8'h80,8'h00,8'hca,8'hcb,8'hcc,8'hcd,8'hce,8'hcf,8'hc0,
          8'h00,8'h8a,8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h00,8'hda,8'hdb,8'hdc,
          8'hdd,8'hde,8'hdf,8'hd0,8'h00,8'h00,8'h21,8'h22,8'h23,8'h24,8'h5b,8'h5c,
          8'h00,8'h5e,8'h5f,8'h00,8'h9c,8'h9d,8'h9e,8'h9f,8'hba,8'hbb,8'hbc,8'hbd,
          8'hbe,8'hbf,8'h9a,8'h9b,8'h00}
    };

    typedef enum logic [1:0] {
        OP_DECODE  = 2'd0,
        OP_ENCODE  = 2'd1,
        OP_RESTART = 2'd2
    } t_op;

    typedef enum logic {
        B_FIRST  = 1'b0,
        B_SECOND = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] in_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       error;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic                hit;
        logic [SYM_IX_W-1:0] ix;
    } t_find;

    // classified item as it waits between front and back
    typedef struct packed {
        t_op                          op;
        logic                         in_range;
        logic                         is_null;
        logic                         sel_hit;
        logic [QUAD_W-1:0]            sel_quad;
        logic [NUM_QUADRANTS-1:0]     hit;
        logic [NUM_QUADRANTS-1:0][7:0] val;
    } t_entry;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

    // first position of byte b in quadrant row
    function automatic t_find find_in_row(input logic [QUAD_W-1:0] row,
                                          input logic [7:0] b);
        t_find f;
        f.hit = 1'b0;
        f.ix  = '0;
        for (int i = SYMBOLS - 1; i >= 0; i--) begin
            if (QTAB[row][i] == b) begin
                f.hit = 1'b1;
                f.ix  = SYM_IX_W'(i);
            end
        end
        return f;
    endfunction

endpackage

@@ rtl/qbc_front.sv @@
module qbc_front (
    input  logic              i_valid,
    input  qbc_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_stall,
    output logic              o_push,
    output qbc_pkg::t_entry   o_entry
);

    logic [7:0]    c;
    qbc_pkg::t_find sym;

    assign c       = i_item.in_byte;
    assign o_stall = i_full;
    // unused op code is taken and dropped here
    assign o_push  = i_valid && !i_full &&
                     (i_item.op == qbc_pkg::OP_DECODE || i_item.op == qbc_pkg::OP_ENCODE ||
                      i_item.op == qbc_pkg::OP_RESTART);

    always_comb begin
        qbc_pkg::t_find f;
        logic [7:0]     v;
        f                = '0;
        v                = 8'h00;
        o_entry          = '0;
        o_entry.op       = qbc_pkg::t_op'(i_item.op);
        o_entry.in_range = (c >= qbc_pkg::LOW_CODE) && (c <= qbc_pkg::HIGH_CODE);
        o_entry.is_null  = (c == 8'h00);
        sym              = qbc_pkg::find_in_row('0, c);
        for (int q = qbc_pkg::NUM_QUADRANTS - 1; q >= 0; q--) begin
            if (c == qbc_pkg::SEL_BYTE[q]) begin
                o_entry.sel_hit  = 1'b1;
                o_entry.sel_quad = qbc_pkg::QUAD_W'(q);
            end
        end
        for (int q = 0; q < qbc_pkg::NUM_QUADRANTS; q++) begin
            if (i_item.op == qbc_pkg::OP_ENCODE) begin
                f              = qbc_pkg::find_in_row(qbc_pkg::QUAD_W'(q), c);
                o_entry.hit[q] = f.hit;
                o_entry.val[q] = qbc_pkg::QTAB[0][f.ix];
            end else begin
                v              = qbc_pkg::QTAB[q][sym.ix];
                o_entry.hit[q] = sym.hit &&
                                 (qbc_pkg::QUAD_W'(q) == qbc_pkg::NULL_QUADRANT ||
                                  c == qbc_pkg::NULL_CODE || v != 8'h00);
                o_entry.val[q] = v;
            end
        end
    end

endmodule

@@ rtl/qbc_queue.sv @@
module qbc_queue #(
    parameter int DEPTH = qbc_pkg::QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  qbc_pkg::t_entry        i_entry,
    input  logic                   i_pop,
    output qbc_pkg::t_entry        o_head,
    output qbc_pkg::t_queue_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qbc_pkg::t_entry  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

@@ rtl/qbc_back.sv @@
module qbc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_drop_cr_eof,
    input  qbc_pkg::t_entry        i_head,
    input  qbc_pkg::t_queue_status i_status,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output qbc_pkg::t_out_item     o_out_data,
    input  logic                   i_out_stall
);

    qbc_pkg::t_back_state         r_state, n_state;
    logic                         r_qset, n_qset;
    logic [qbc_pkg::QUAD_W-1:0]   r_quad, n_quad;
    logic [7:0]                   r_second, n_second;
    logic                         r_out_valid, n_out_valid;
    qbc_pkg::t_out_item           r_out, n_out;

    logic [1:0]                   cnt;
    logic [7:0]                   d0, d1;
    logic                         fail;
    logic                         c_qset;
    logic [qbc_pkg::QUAD_W-1:0]   c_quad;
    logic                         slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // work out the results of the head item against the current quadrant
    always_comb begin
        logic       retry;
        logic       found;
        logic [7:0] v;
        cnt    = 2'd0;
        d0     = 8'h00;
        d1     = 8'h00;
        fail   = 1'b0;
        retry  = 1'b0;
        found  = 1'b0;
        v      = i_head.val[r_quad];
        c_qset = r_qset;
        c_quad = r_quad;
        unique case (i_head.op)
            qbc_pkg::OP_DECODE: begin
                if (r_qset) begin
                    if (!i_head.in_range) begin
                        fail = 1'b1;
                    end else if (i_head.hit[r_quad]) begin
                        if (!(i_drop_cr_eof &&
                              (v == qbc_pkg::CR_BYTE || v == qbc_pkg::EOF_BYTE))) begin
                            cnt = 2'd1;
                            d0  = v;
                        end
                    end else begin
                        retry = 1'b1;
                    end
                end
                if (!r_qset || retry) begin
                    if (i_head.sel_hit) begin
                        c_qset = 1'b1;
                        c_quad = i_head.sel_quad;
                    end else begin
                        fail = 1'b1;
                    end
                end
            end
            qbc_pkg::OP_ENCODE: begin
                if (i_head.is_null) begin
                    if (r_qset && r_quad == qbc_pkg::NULL_QUADRANT) begin
                        cnt = 2'd1;
                        d0  = qbc_pkg::NULL_CODE;
                    end else begin
                        cnt    = 2'd2;
                        d0     = qbc_pkg::SEL_BYTE[qbc_pkg::NULL_QUADRANT];
                        d1     = qbc_pkg::NULL_CODE;
                        c_qset = 1'b1;
                        c_quad = qbc_pkg::NULL_QUADRANT;
                    end
                end else if (r_qset && i_head.hit[r_quad]) begin
                    cnt = 2'd1;
                    d0  = v;
                end else begin
                    for (int q = qbc_pkg::NUM_QUADRANTS - 1; q >= 0; q--) begin
                        if (i_head.hit[q] && !(r_qset && r_quad == qbc_pkg::QUAD_W'(q))) begin
                            found  = 1'b1;
                            d0     = qbc_pkg::SEL_BYTE[q];
                            d1     = i_head.val[q];
                            c_quad = qbc_pkg::QUAD_W'(q);
                        end
                    end
                    if (found) begin
                        cnt    = 2'd2;
                        c_qset = 1'b1;
                    end else begin
                        fail = 1'b1;
                    end
                end
            end
            qbc_pkg::OP_RESTART: begin
                c_qset = 1'b0;
            end
            default: begin
                c_qset = r_qset;
            end
        endcase
        if (fail) begin
            cnt    = 2'd1;
            d0     = 8'h00;
            c_qset = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            qbc_pkg::B_FIRST: begin
                if (!i_status.empty && cnt == 2'd2 && slot_free) begin
                    n_state = qbc_pkg::B_SECOND;
                end
            end
            qbc_pkg::B_SECOND: begin
                if (slot_free) begin
                    n_state = qbc_pkg::B_FIRST;
                end
            end
            default: n_state = qbc_pkg::B_FIRST;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        n_qset      = r_qset;
        n_quad      = r_quad;
        n_second    = r_second;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            qbc_pkg::B_FIRST: begin
                if (!i_status.empty && (cnt == 2'd0 || slot_free)) begin
                    o_pop  = 1'b1;
                    n_qset = c_qset;
                    n_quad = c_quad;
                    if (cnt != 2'd0) begin
                        n_out_valid     = 1'b1;
                        n_out.data_byte = d0;
                        n_out.error     = fail;
                        n_out.last      = (cnt == 2'd1);
                        n_second        = d1;
                    end
                end
            end
            qbc_pkg::B_SECOND: begin
                if (slot_free) begin
                    n_out_valid     = 1'b1;
                    n_out.data_byte = r_second;
                    n_out.error     = 1'b0;
                    n_out.last      = 1'b1;
                end
            end
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= qbc_pkg::B_FIRST;
            r_qset      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_qset      <= n_qset;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quad   <= n_quad;
        r_second <= n_second;
        r_out    <= n_out;
    end

endmodule

@@ rtl/quadrant_byte_codec_core.sv @@
// the first result of an item passes through the classify queue and then the
// output register
// throughput: one input transfer per cycle while the classify queue has room;
// the back end retires one result per cycle while the output is not stalled;
// a two-result encode holds back the next item until its second is registered
// reset: synchronous active low; empties the queue and output register,
// quadrant becomes unset, drop_cr_eof clears to 0
module quadrant_byte_codec_core #(
    parameter int QUEUE_DEPTH = qbc_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  qbc_pkg::t_in_item                i_in_data,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output qbc_pkg::t_out_item               o_out_data,
    input  logic                             i_out_stall,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [qbc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [qbc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [qbc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    logic                   r_drop_cr_eof;
    logic                   push, pop;
    qbc_pkg::t_entry        entry, head;
    qbc_pkg::t_queue_status status;
    logic                   reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[qbc_pkg::APB_ADDR_W-1] == qbc_pkg::REG_DROP_CR_EOF);
    assign prdata  = reg_sel ? {{(qbc_pkg::APB_DATA_W-1){1'b0}}, r_drop_cr_eof} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_cr_eof <= 1'b0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_drop_cr_eof <= pwdata[0];
        end
    end

    qbc_front u_front (
        .i_valid (i_in_valid),
        .i_item  (i_in_data),
        .i_full  (status.full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_entry (entry)
    );

    qbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (status)
    );

    qbc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_drop_cr_eof (r_drop_cr_eof),
        .i_head        (head),
        .i_status      (status),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_stall   (i_out_stall)
    );

endmodule

@@ rtl/qbc_checker.sv @@
`include "assert_macros.svh"

module qbc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input qbc_pkg::t_out_item o_out_data,
    input logic               i_out_stall
);

    logic out_xfer;
    logic err_xfer;
    logic err_shape;
    logic mid_xfer;
    logic is_sel;
    logic pair_end;
    logic out_wait;

    assign out_xfer  = o_out_valid && !i_out_stall;
    assign err_xfer  = out_xfer && o_out_data.error;
    assign err_shape = o_out_data.last && (o_out_data.data_byte == 8'h00);
    assign mid_xfer  = out_xfer && !o_out_data.last;
    assign is_sel    = (o_out_data.data_byte == qbc_pkg::SEL_BYTE[0]) ||
                       (o_out_data.data_byte == qbc_pkg::SEL_BYTE[1]) ||
                       (o_out_data.data_byte == qbc_pkg::SEL_BYTE[2]) ||
                       (o_out_data.data_byte == qbc_pkg::SEL_BYTE[3]);
    assign pair_end  = o_out_valid && o_out_data.last && !o_out_data.error;
    assign out_wait  = o_out_valid && i_out_stall;

    `QBC_ASSERT_IMP(a_error_is_last_zero, i_clk, i_rst_n, err_xfer, err_shape, "bad error result")
    `QBC_ASSERT_IMP(a_first_is_selector, i_clk, i_rst_n, mid_xfer, is_sel, "first not a selector")
    `QBC_ASSERT_NXT(a_pair_follows, i_clk, i_rst_n, mid_xfer, pair_end, "selector left alone")
    `QBC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_wait, o_out_valid && $stable(o_out_data), "held output changed")
    `QBC_ASSERT_IMP(a_reset_empty, i_clk, i_rst_n, $past(!i_rst_n), !o_in_stall && !o_out_valid, "busy after reset")

endmodule

bind quadrant_byte_codec_core qbc_checker u_qbc_checker (.*);

@@ tb/tb_quadrant_byte_codec_core.sv @@
`timescale 1ns / 1ps

module tb_quadrant_byte_codec_core;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] QUAD_NONE = 3'd4;
    localparam logic [qbc_pkg::APB_ADDR_W-1:0] ADDR_DROP_CR_EOF =
        qbc_pkg::APB_ADDR_W'(4 * qbc_pkg::REG_DROP_CR_EOF);
    localparam int LONG_HOLD = 60;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    qbc_pkg::t_in_item in_data = '0;
    logic in_stall;
    logic out_valid;
    qbc_pkg::t_out_item out_data;
    logic out_stall = 1'b0;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [qbc_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [qbc_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [qbc_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    qbc_pkg::t_in_item bytes_to_send[$];
    qbc_pkg::t_out_item codec_results_due[$];
    qbc_pkg::t_out_item due_item;

    logic [2:0] quad_now = QUAD_NONE;
    logic drop_now = 1'b0;
    logic hold_wanted = 1'b0;
    bit hold_done = 1'b0;

    int send_gap = 0;
    int send_calm = 0;
    int recv_gap = 0;
    int recv_calm = 0;
    int hold_left = 0;

    int fails = 0;
    int items_taken = 0;
    int results_seen = 0;
    int error_results = 0;
    int pair_encodes = 0;
    int dropped_bytes = 0;

    quadrant_byte_codec_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_stall(out_stall),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #1 clk = ~clk;

    function automatic int row_index(input int row, input logic [7:0] b);
        for (int i = 0; i < qbc_pkg::SYMBOLS; i++) begin
            if (qbc_pkg::QTAB[row][i] == b) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int selector_quad(input logic [7:0] b);
        for (int q = 0; q < qbc_pkg::NUM_QUADRANTS; q++) begin
            if (qbc_pkg::SEL_BYTE[q] == b) begin
                return q;
            end
        end
        return -1;
    endfunction

    // runs of back-to-back transfers now and then, else a random idle gap
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = 25;
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    task automatic result_due(input logic [7:0] data, input logic err, input logic fin);
        qbc_pkg::t_out_item r;
        r.data_byte = data;
        r.error = err;
        r.last = fin;
        codec_results_due.push_back(r);
    endtask

    task automatic code_error();
        quad_now = QUAD_NONE;
        result_due(8'h00, 1'b1, 1'b1);
    endtask

    task automatic codec_predict(input qbc_pkg::t_in_item it);
        logic [7:0] c;
        logic [7:0] v;
        logic [2:0] null_quad;
        logic retry;
        logic found;
        int ix;
        int q;
        c = it.in_byte;
        null_quad = {1'b0, qbc_pkg::NULL_QUADRANT};
        case (it.op)
            qbc_pkg::OP_DECODE: begin
                retry = 1'b1;
                if (quad_now != QUAD_NONE) begin
                    if (c < qbc_pkg::LOW_CODE || c > qbc_pkg::HIGH_CODE) begin
                        code_error();
                        retry = 1'b0;
                    end else begin
                        ix = row_index(0, c);
                        if (ix >= 0 && (quad_now == null_quad || c == qbc_pkg::NULL_CODE ||
                                        qbc_pkg::QTAB[quad_now[1:0]][ix] != 8'h00)) begin
                            v = qbc_pkg::QTAB[quad_now[1:0]][ix];
                            if (drop_now &&
                                (v == qbc_pkg::CR_BYTE || v == qbc_pkg::EOF_BYTE)) begin
                                dropped_bytes++;
                            end else begin
                                result_due(v, 1'b0, 1'b1);
                            end
                            retry = 1'b0;
                        end else begin
                            quad_now = QUAD_NONE;
                        end
                    end
                end
                if (retry) begin
                    q = selector_quad(c);
                    if (q < 0) begin
                        code_error();
                    end else begin
                        quad_now = 3'(q);
                    end
                end
            end
            qbc_pkg::OP_ENCODE: begin
                if (c == 8'h00) begin
                    if (quad_now != null_quad) begin
                        quad_now = null_quad;
                        result_due(qbc_pkg::SEL_BYTE[qbc_pkg::NULL_QUADRANT], 1'b0, 1'b0);
                        pair_encodes++;
                    end
                    result_due(qbc_pkg::NULL_CODE, 1'b0, 1'b1);
                end else begin
                    found = 1'b0;
                    if (quad_now != QUAD_NONE) begin
                        ix = row_index(int'(quad_now), c);
                        if (ix >= 0) begin
                            result_due(qbc_pkg::QTAB[0][ix], 1'b0, 1'b1);
                            found = 1'b1;
                        end
                    end
                    for (q = 0; q < qbc_pkg::NUM_QUADRANTS && !found; q++) begin
                        if (3'(q) != quad_now) begin
                            ix = row_index(q, c);
                            if (ix >= 0) begin
                                quad_now = 3'(q);
                                result_due(qbc_pkg::SEL_BYTE[q], 1'b0, 1'b0);
                                result_due(qbc_pkg::QTAB[0][ix], 1'b0, 1'b1);
                                pair_encodes++;
                                found = 1'b1;
                            end
                        end
                    end
                    if (!found) begin
                        code_error();
                    end
                end
            end
            qbc_pkg::OP_RESTART: begin
                quad_now = QUAD_NONE;
            end
            default: begin
            end
        endcase
    endtask

    // sender
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                codec_predict(in_data);
                items_taken++;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (bytes_to_send.size() > 0) begin
                    in_data <= bytes_to_send.pop_front();
                    in_valid <= 1'b1;
                    send_gap = draw_gap(send_calm);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (hold_wanted && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (out_valid && !out_stall) begin
                    recv_gap = draw_gap(recv_calm);
                end
                if (recv_gap > 0) begin
                    recv_gap--;
                    out_stall <= 1'b1;
                end else begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // result check
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (out_data.error) begin
                error_results++;
            end
            if (codec_results_due.size() == 0) begin
                $error("unexpected result transfer: data_byte=%02h error=%0b last=%0b",
                       out_data.data_byte, out_data.error, out_data.last);
                fails++;
            end else begin
                due_item = codec_results_due.pop_front();
                if (out_data.data_byte !== due_item.data_byte) begin
                    $error("data_byte: expected %02h, got %02h",
                           due_item.data_byte, out_data.data_byte);
                    fails++;
                end
                if (out_data.error !== due_item.error) begin
                    $error("error: expected %0b, got %0b", due_item.error, out_data.error);
                    fails++;
                end
                if (out_data.last !== due_item.last) begin
                    $error("last: expected %0b, got %0b", due_item.last, out_data.last);
                    fails++;
                end
            end
        end
    end

    task automatic offer(input logic [1:0] op, input logic [7:0] b);
        qbc_pkg::t_in_item it;
        it.op = op;
        it.in_byte = b;
        bytes_to_send.push_back(it);
    endtask

    task automatic cfg_write(input logic val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_DROP_CR_EOF;
        pwdata <= qbc_pkg::APB_DATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        drop_now = val;
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== qbc_pkg::APB_DATA_W'(val)) begin
            $error("drop_cr_eof readback: expected %0h, got %0h",
                   qbc_pkg::APB_DATA_W'(val), prdata);
            fails++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic fill_random(input int count);
        int n;
        int pick;
        logic [1:0] op;
        logic [7:0] b;
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 99);
            b = 8'($urandom_range(0, 255));
            if (pick < 35) begin
                op = qbc_pkg::OP_ENCODE;
                if ($urandom_range(0, 15) == 0) begin
                    b = 8'h00;
                end
            end else if (pick < 85) begin
                op = qbc_pkg::OP_DECODE;
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    b = qbc_pkg::SEL_BYTE[$urandom_range(0, qbc_pkg::NUM_QUADRANTS - 1)];
                end else if (pick < 85) begin
                    b = qbc_pkg::QTAB[0][$urandom_range(0, qbc_pkg::SYMBOLS - 1)];
                end
            end else if (pick < 94) begin
                op = qbc_pkg::OP_RESTART;
            end else begin
                op = OP_UNUSED;
            end
            offer(op, b);
            if (op != OP_UNUSED) begin
                n++;
            end
        end
    endtask

    task automatic drain();
        while (bytes_to_send.size() > 0 || in_valid || codec_results_due.size() > 0) begin
            @(posedge clk);
        end
        repeat (qbc_pkg::QUEUE_DEPTH + 4) @(posedge clk);
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        cfg_write(1'b0);
        // decode with no quadrant, selects, range edges, unmapped retry
        offer(qbc_pkg::OP_DECODE, 8'h40);
        offer(qbc_pkg::OP_DECODE, qbc_pkg::SEL_BYTE[0]);
        offer(qbc_pkg::OP_DECODE, 8'h40);
        offer(qbc_pkg::OP_DECODE, 8'hf9);
        offer(qbc_pkg::OP_DECODE, 8'h3f);
        offer(qbc_pkg::OP_DECODE, qbc_pkg::SEL_BYTE[1]);
        offer(qbc_pkg::OP_DECODE, qbc_pkg::NULL_CODE);
        offer(qbc_pkg::OP_DECODE, 8'hfa);
        offer(qbc_pkg::OP_DECODE, qbc_pkg::SEL_BYTE[2]);
        offer(qbc_pkg::OP_DECODE, 8'h40);
        offer(qbc_pkg::OP_DECODE, 8'hd5);
        offer(qbc_pkg::OP_DECODE, qbc_pkg::SEL_BYTE[3]);
        offer(qbc_pkg::OP_DECODE, qbc_pkg::NULL_CODE);
        offer(qbc_pkg::OP_DECODE, 8'h82);
        offer(qbc_pkg::OP_DECODE, 8'hff);
        offer(qbc_pkg::OP_DECODE, qbc_pkg::SEL_BYTE[0]);
        offer(qbc_pkg::OP_DECODE, 8'h00);
        // encode: null byte twice, quadrant changes and stays
        offer(qbc_pkg::OP_ENCODE, 8'h00);
        offer(qbc_pkg::OP_ENCODE, 8'h00);
        offer(qbc_pkg::OP_ENCODE, 8'h41);
        offer(qbc_pkg::OP_ENCODE, 8'h42);
        offer(qbc_pkg::OP_ENCODE, 8'hff);
        offer(qbc_pkg::OP_ENCODE, 8'h80);
        offer(qbc_pkg::OP_RESTART, 8'hff);
        offer(qbc_pkg::OP_DECODE, qbc_pkg::NULL_CODE);
        offer(OP_UNUSED, 8'haa);
        fill_random(190);
        drain();

        cfg_write(1'b1);
        // cr and eof dropped, quadrant kept
        offer(qbc_pkg::OP_DECODE, qbc_pkg::SEL_BYTE[2]);
        offer(qbc_pkg::OP_DECODE, 8'hd5);
        offer(qbc_pkg::OP_DECODE, 8'h5d);
        offer(qbc_pkg::OP_DECODE, 8'hc2);
        offer(qbc_pkg::OP_ENCODE, 8'h0d);
        fill_random(205);
        drain();

        cfg_write(1'b0);
        hold_wanted <= 1'b1;
        fill_random(210);
        drain();

        cfg_write(1'b1);
        fill_random(210);
        drain();

        $display("covered %0d input transfers and %0d result transfers", items_taken,
                 results_seen);
        $display("  %0d error results, %0d two-byte encodes, %0d dropped cr/eof bytes",
                 error_results, pair_encodes, dropped_bytes);
        if (fails == 0) begin
            $display("tb_quadrant_byte_codec_core: done, clean");
        end else begin
            $display("tb_quadrant_byte_codec_core: done, errors");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("tb_quadrant_byte_codec_core: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/qbc_pkg.sv
rtl/qbc_front.sv
rtl/qbc_queue.sv
rtl/qbc_back.sv
rtl/quadrant_byte_codec_core.sv
rtl/qbc_checker.sv
tb/tb_quadrant_byte_codec_core.sv
